>>> sv/isort_pkg.sv
package isort_pkg;

  localparam int MAX_ELEMENTS = 16;
  localparam int IDX_W        = $clog2(MAX_ELEMENTS);
  localparam int CNT_W        = $clog2(MAX_ELEMENTS + 1);
  localparam int VALUE_W      = 32;
  localparam int ORIG_W       = 4;
  localparam int QUEUE_DEPTH  = 2;
  localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic {
    OP_STORE,
    OP_DROP
  } cmd_op_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_SCAN,
    BK_SWAP,
    BK_EMIT
  } back_state_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0] value;
    logic                      last;
  } item_t;

  typedef struct packed {
    logic [ORIG_W-1:0]         orig_index;
    logic signed [VALUE_W-1:0] sorted_value;
    logic                      final_res;
    logic                      overflow;
  } result_t;

  // One classified beat handed from the front end to the back end.
  typedef struct packed {
    cmd_op_t                   op;
    logic                      last;
    logic [IDX_W-1:0]          index;
    logic signed [VALUE_W-1:0] value;
    logic [CNT_W-1:0]          count;
    logic                      dropped;
  } cmd_t;

endpackage

>>> sv/isort_front.sv
module isort_front (
  input  logic                clk,
  input  logic                rst,
  input  isort_pkg::item_t    item,
  input  logic                item_valid,
  output logic                item_ready,
  output isort_pkg::cmd_t     cmd,
  output logic                cmd_push,
  input  logic                queue_full
);
  import isort_pkg::*;

  logic [CNT_W-1:0] element_count;
  logic             dropped_flag;
  logic             set_full;
  logic [CNT_W-1:0] count_next;
  logic             dropped_next;

  assign item_ready   = !queue_full;
  assign cmd_push     = item_valid && item_ready;
  assign set_full     = (element_count == CNT_W'(MAX_ELEMENTS));
  assign count_next   = set_full ? element_count : element_count + CNT_W'(1);
  assign dropped_next = dropped_flag | set_full;

  always_comb begin
    cmd.op      = set_full ? OP_DROP : OP_STORE;
    cmd.last    = item.last;
    cmd.index   = element_count[IDX_W-1:0];
    cmd.value   = item.value;
    cmd.count   = count_next;
    cmd.dropped = dropped_next;
  end

  // Restart the set count after the closing beat.
  always_ff @(posedge clk) begin
    if (rst) begin
      element_count <= '0;
      dropped_flag  <= 1'b0;
    end else if (cmd_push) begin
      if (item.last) begin
        element_count <= '0;
        dropped_flag  <= 1'b0;
      end else begin
        element_count <= count_next;
        dropped_flag  <= dropped_next;
      end
    end
  end

endmodule

>>> sv/isort_queue.sv
module isort_queue (
  input  logic             clk,
  input  logic             rst,
  input  isort_pkg::cmd_t  cmd_in,
  input  logic             push,
  output logic             full,
  output isort_pkg::cmd_t  cmd_out,
  output logic             not_empty,
  input  logic             pop
);
  import isort_pkg::*;

  cmd_t              slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] fill;

  assign full      = (fill == QCNT_W'(QUEUE_DEPTH));
  assign not_empty = (fill != '0);
  assign cmd_out   = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= cmd_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + QPTR_W'(1);
      end
      if (push && !pop) begin
        fill <= fill + QCNT_W'(1);
      end else if (pop && !push) begin
        fill <= fill - QCNT_W'(1);
      end
    end
  end

endmodule

>>> sv/isort_back.sv
module isort_back (
  input  logic               clk,
  input  logic               rst,
  input  isort_pkg::cmd_t    cmd,
  input  logic               cmd_valid,
  output logic               cmd_pop,
  output isort_pkg::result_t result,
  output logic               result_valid,
  input  logic               result_ready
);
  import isort_pkg::*;

  logic signed [VALUE_W-1:0] value_store [MAX_ELEMENTS];
  logic [IDX_W-1:0]          perm_store  [MAX_ELEMENTS];

  back_state_t               state;
  back_state_t               state_next;
  logic [CNT_W-1:0]          n_elems;
  logic [CNT_W-1:0]          pass_idx;
  logic [CNT_W-1:0]          scan_idx;
  logic [IDX_W-1:0]          best_pos;
  logic [IDX_W-1:0]          best_perm;
  logic [IDX_W-1:0]          head_perm;
  logic signed [VALUE_W-1:0] best_key;
  logic                      set_overflow;

  logic [IDX_W-1:0]          scan_perm;
  logic signed [VALUE_W-1:0] scan_key;
  logic                      scan_end;
  logic                      scan_head;
  logic [CNT_W-1:0]          pass_inc;
  logic                      out_free;
  logic                      emit_fire;
  logic                      start_sort;

  // One read path: permutation entry, then its value.
  assign scan_perm = perm_store[scan_idx[IDX_W-1:0]];
  assign scan_key  = value_store[scan_perm];
  assign scan_end  = (scan_idx == n_elems - CNT_W'(1));
  assign scan_head = (scan_idx == pass_idx);
  assign pass_inc  = pass_idx + CNT_W'(1);
  assign out_free  = !result_valid || result_ready;

  always_comb begin
    state_next = state;
    unique case (state)
      BK_IDLE: begin
        if (cmd_valid && cmd.last) state_next = BK_SCAN;
      end
      BK_SCAN: begin
        if (scan_end) state_next = BK_SWAP;
      end
      BK_SWAP: begin
        state_next = (pass_inc == n_elems) ? BK_EMIT : BK_SCAN;
      end
      BK_EMIT: begin
        if (out_free && scan_end) state_next = BK_IDLE;
      end
      default: state_next = BK_IDLE;
    endcase
  end

  always_comb begin
    cmd_pop   = 1'b0;
    emit_fire = 1'b0;
    unique case (state)
      BK_IDLE: cmd_pop   = cmd_valid;
      BK_EMIT: emit_fire = out_free;
      default: begin
        cmd_pop   = 1'b0;
        emit_fire = 1'b0;
      end
    endcase
  end

  assign start_sort = cmd_pop && cmd.last;

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= BK_IDLE;
      result_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (emit_fire) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_pop && cmd.op == OP_STORE) begin
      value_store[cmd.index] <= cmd.value;
    end
  end

  // Seed the identity permutation, then swap the pass minimum into place.
  always_ff @(posedge clk) begin
    if (start_sort) begin
      for (int x = 0; x < MAX_ELEMENTS; x++) begin
        perm_store[x] <= IDX_W'(x);
      end
    end else if (state == BK_SWAP) begin
      if (best_pos != pass_idx[IDX_W-1:0]) begin
        perm_store[best_pos] <= head_perm;
      end
      perm_store[pass_idx[IDX_W-1:0]] <= best_perm;
    end
  end

  always_ff @(posedge clk) begin
    if (start_sort) begin
      n_elems      <= cmd.count;
      set_overflow <= cmd.dropped;
      pass_idx     <= '0;
      scan_idx     <= '0;
    end else begin
      unique case (state)
        BK_SCAN: begin
          // Keep the first strict minimum only.
          if (scan_head || scan_key < best_key) begin
            best_pos  <= scan_idx[IDX_W-1:0];
            best_key  <= scan_key;
            best_perm <= scan_perm;
          end
          if (scan_head) begin
            head_perm <= scan_perm;
          end
          scan_idx <= scan_idx + CNT_W'(1);
        end
        BK_SWAP: begin
          pass_idx <= pass_inc;
          scan_idx <= (pass_inc == n_elems) ? '0 : pass_inc;
        end
        BK_EMIT: begin
          if (emit_fire) begin
            result.orig_index   <= ORIG_W'(scan_perm);
            result.sorted_value <= scan_key;
            result.final_res    <= scan_end;
            result.overflow     <= set_overflow;
            scan_idx            <= scan_idx + CNT_W'(1);
          end
        end
        default: begin
          pass_idx <= pass_idx;
        end
      endcase
    end
  end

endmodule

>>> sv/index_selection_sort_core.sv
// Index selection sort core. Signed 32-bit values arrive one beat at a time
// and are stored with their arrival index; the beat marked last closes the
// set and starts a selection sort over an index permutation (identity at the
// start). Each pass keeps the first strict minimum of the remaining entries
// and swaps it into place, so equal values come out in that exact, unstable
// order. One result beat per stored element follows, lowest value first,
// carrying the original index, the value, final_res on the highest position
// and overflow on every beat of a set that lost elements. Up to MAX_ELEMENTS
// (16) elements are held; beats beyond that are dropped and flagged, and a
// dropped beat marked last still closes the set.
// Timing: the front end takes one beat per cycle as long as its two-entry
// command queue has room, so up to two beats of the next set wait there while
// the back end works. The back end handles one queued beat per cycle while
// idle and takes no new beat until the last result of a set is out. It sorts
// with a single comparator scanning one entry per cycle, then drains one
// result beat at a time, holding each while the consumer stalls.
module index_selection_sort_core (
  input  logic               clk,
  input  logic               rst,
  input  isort_pkg::item_t   item,
  input  logic               item_valid,
  output logic               item_ready,
  output isort_pkg::result_t result,
  output logic               result_valid,
  input  logic               result_ready
);
  import isort_pkg::*;

  cmd_t front_cmd;
  cmd_t back_cmd;
  logic cmd_push;
  logic cmd_pop;
  logic queue_full;
  logic queue_not_empty;

  // Classify each beat as store or drop and stamp the running set count.
  isort_front u_front (
    .clk        (clk),
    .rst        (rst),
    .item       (item),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .cmd        (front_cmd),
    .cmd_push   (cmd_push),
    .queue_full (queue_full)
  );

  // Decouple intake from the sort so each side stalls on its own.
  isort_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .cmd_in    (front_cmd),
    .push      (cmd_push),
    .full      (queue_full),
    .cmd_out   (back_cmd),
    .not_empty (queue_not_empty),
    .pop       (cmd_pop)
  );

  // Store values, sort on the closing beat, drain through the output register.
  isort_back u_back (
    .clk          (clk),
    .rst          (rst),
    .cmd          (back_cmd),
    .cmd_valid    (queue_not_empty),
    .cmd_pop      (cmd_pop),
    .result       (result),
    .result_valid (result_valid),
    .result_ready (result_ready)
  );

endmodule
